// ===== rtl/assert_macros.svh =====
// Assertion helper macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Trigger in one cycle implies the condition in the next one.
`define ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// ===== rtl/bsa_pkg.sv =====
// Types and codes for the banker's safety allocator.
package bsa_pkg;

  // Input opcodes
  typedef enum logic [2:0] {
    OP_WR_MAX   = 3'd0,
    OP_WR_ALLOC = 3'd1,
    OP_WR_AVAIL = 3'd2,
    OP_REQUEST  = 3'd3,
    OP_RELEASE  = 3'd4,
    OP_CHECK    = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_EXCEEDS   = 3'd1,
    STS_NOT_AVAIL = 3'd2,
    STS_UNSAFE    = 3'd3,
    STS_BAD_PROC  = 3'd4
  } status_t;

  // Configuration register indexes
  localparam logic CFG_PROCESS_COUNT  = 1'b0;
  localparam logic CFG_RESOURCE_COUNT = 1'b1;

  // Decoded command kinds
  typedef enum logic [2:0] {
    K_WR_MAX,
    K_WR_ALLOC,
    K_WR_AVAIL,
    K_STAGE,
    K_REQ,
    K_RELEASE,
    K_CHECK
  } kind_t;

  // Back-end sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_EV_RD,
    S_EV_EX,
    S_AP_RD,
    S_AP_EX,
    S_SC_INIT,
    S_SC_P,
    S_SC_RD,
    S_SC_EX,
    S_SC_ARD,
    S_SC_AEX,
    S_SC_END,
    S_RB_RD,
    S_RB_EX,
    S_RL_RD,
    S_RL_EX,
    S_EMIT,
    S_SEQ
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  proc_index;
    logic [2:0]  res_index;
    logic [15:0] amount;
    logic        final_element;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_safe;
    logic        seq_valid;
    logic [3:0]  seq_process;
    logic [15:0] blocked_mask;
    logic        last;
  } out_t;

  // Classified command handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  proc_index;
    logic [2:0]  res_index;
    logic [15:0] amount;
    logic        p_ok;
    logic        r_ok;
  } cmd_t;

endpackage

// ===== rtl/bsa_front.sv =====
// Front end: accepts input words and classifies them into commands.
module bsa_front import bsa_pkg::*; #(
  parameter int PROCS     = 16,
  parameter int RESOURCES = 8
) (
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_word,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_cmd
);

  logic known;

  // Decode opcode; unused codes are taken and dropped
  always_comb begin
    known            = 1'b1;
    q_cmd.kind       = K_CHECK;
    q_cmd.proc_index = in_word.proc_index;
    q_cmd.res_index  = in_word.res_index;
    q_cmd.amount     = in_word.amount;
    // Index range flags for the stores
    q_cmd.p_ok       = 32'(in_word.proc_index) < PROCS;
    q_cmd.r_ok       = 32'(in_word.res_index) < RESOURCES;
    case (in_word.opcode)
      OP_WR_MAX:   q_cmd.kind = K_WR_MAX;
      OP_WR_ALLOC: q_cmd.kind = K_WR_ALLOC;
      OP_WR_AVAIL: q_cmd.kind = K_WR_AVAIL;
      OP_REQUEST:  q_cmd.kind = in_word.final_element ? K_REQ : K_STAGE;
      OP_RELEASE:  q_cmd.kind = K_RELEASE;
      OP_CHECK:    q_cmd.kind = K_CHECK;
      default:     known = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && known;

endmodule

// ===== rtl/bsa_queue.sv =====
// Two-entry command queue between front and back.
module bsa_queue import bsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  assign head  = slots[rd_ptr];
  assign full  = count == 2'd2;
  assign empty = count == 2'd0;

endmodule

// ===== rtl/bsa_back.sv =====
// Back end: matrices, request checks, safety scan and result word register.
module bsa_back import bsa_pkg::*; #(
  parameter int PROCS     = 16,
  parameter int RESOURCES = 8,
  parameter int UNIT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [4:0] process_count,
  input  logic [3:0] resource_count,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_word
);

  localparam int PW    = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int RW    = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int CW    = $clog2(PROCS + 1);
  localparam int RCW   = $clog2(RESOURCES + 1);
  localparam int AW    = PW + RW;
  localparam int DEPTH = PROCS * (2 ** RW);
  localparam int WW    = UNIT_BITS + $clog2(PROCS + 1);

  state_t state, state_next;
  cmd_t   cur;

  logic [CW-1:0]  np;
  logic [RCW-1:0] nr;
  logic [CW-1:0]  p_cnt;
  logic [CW-1:0]  n_cnt;
  logic [CW-1:0]  e_cnt;
  logic [RCW-1:0] r_cnt;
  logic [PROCS-1:0] done;
  logic [PROCS-1:0] all_mask;
  logic progress;
  logic ex_any;
  logic na_any;
  logic [2:0]  res_status;
  logic        res_safe;
  logic [15:0] res_mask;

  logic [UNIT_BITS-1:0] free_units    [RESOURCES];
  logic [UNIT_BITS-1:0] request_stage [RESOURCES];
  logic [WW-1:0]        work          [RESOURCES];
  logic [PW-1:0]        seq           [PROCS];

  // Matrix memories with per-entry valid bits (unwritten reads as zero)
  logic [UNIT_BITS-1:0] max_mem   [DEPTH];
  logic [UNIT_BITS-1:0] alloc_mem [DEPTH];
  logic [DEPTH-1:0]     max_vld;
  logic [DEPTH-1:0]     alloc_vld;
  logic [UNIT_BITS-1:0] max_rd;
  logic [UNIT_BITS-1:0] alloc_rd;

  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        cfg_addr;
  logic [PW-1:0]        p_sel;
  logic [RW-1:0]        ri;
  logic                 r_end;
  logic                 p_end;
  logic                 bad_proc;
  logic                 max_we;
  logic                 alloc_we;
  logic [UNIT_BITS-1:0] alloc_wd;
  logic                 can_emit;
  logic                 emit;
  out_t                 emit_word;

  logic [UNIT_BITS:0]   need_s;
  logic                 need_neg;
  logic [UNIT_BITS:0]   rel_sum;
  logic                 exceeds;
  logic                 no_fit;

  // Effective counts in use
  assign np = (32'(process_count) > PROCS) ? CW'(PROCS) : CW'(process_count);
  assign nr = (32'(resource_count) > RESOURCES) ? RCW'(RESOURCES) : RCW'(resource_count);

  assign ri       = r_cnt[RW-1:0];
  assign r_end    = r_cnt >= nr;
  assign p_end    = p_cnt >= np;
  assign bad_proc = 32'(cur.proc_index) >= 32'(np);
  assign can_emit = !out_valid || !out_stall;

  // Scan states address by scan counter, others by the command's process
  always_comb begin
    case (state)
      S_SC_RD, S_SC_EX, S_SC_ARD, S_SC_AEX: p_sel = p_cnt[PW-1:0];
      default:                              p_sel = PW'(cur.proc_index);
    endcase
  end
  assign rd_addr  = {p_sel, ri};
  assign cfg_addr = {PW'(cur.proc_index), RW'(cur.res_index)};

  // Need and comparisons on the registered read data
  assign need_s   = {1'b0, max_rd} - {1'b0, alloc_rd};
  assign need_neg = need_s[UNIT_BITS];
  assign exceeds  = need_neg || (request_stage[ri] > need_s[UNIT_BITS-1:0]);
  assign no_fit   = !need_neg && (WW'(need_s[UNIT_BITS-1:0]) > work[ri]);
  assign rel_sum  = {1'b0, free_units[ri]} + {1'b0, alloc_rd};

  // Mask of processes in use
  always_comb begin
    for (int i = 0; i < PROCS; i++) all_mask[i] = 32'(i) < 32'(np);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (!q_empty) state_next = S_DISP;
      S_DISP: begin
        case (cur.kind)
          K_STAGE:   state_next = S_IDLE;
          K_REQ:     state_next = bad_proc ? S_EMIT : S_EV_RD;
          K_RELEASE: state_next = bad_proc ? S_EMIT : S_RL_RD;
          K_CHECK:   state_next = S_SC_INIT;
          default:   state_next = S_EMIT;
        endcase
      end
      S_EV_RD: state_next = S_EV_EX;
      S_EV_EX: begin
        if (!r_end)                  state_next = S_EV_RD;
        else if (ex_any || na_any)   state_next = S_EMIT;
        else                         state_next = S_AP_RD;
      end
      S_AP_RD:   state_next = S_AP_EX;
      S_AP_EX:   state_next = r_end ? S_SC_INIT : S_AP_RD;
      S_SC_INIT: state_next = S_SC_P;
      S_SC_P: begin
        if (p_end) begin
          if (!(progress && n_cnt < np)) state_next = S_SC_END;
        end else if (!done[p_cnt[PW-1:0]]) begin
          state_next = S_SC_RD;
        end
      end
      S_SC_RD: state_next = S_SC_EX;
      S_SC_EX: begin
        if (r_end)       state_next = S_SC_ARD;
        else if (no_fit) state_next = S_SC_P;
        else             state_next = S_SC_RD;
      end
      S_SC_ARD: state_next = S_SC_AEX;
      S_SC_AEX: state_next = r_end ? S_SC_P : S_SC_ARD;
      S_SC_END: begin
        if (cur.kind == K_REQ)        state_next = (n_cnt == np) ? S_EMIT : S_RB_RD;
        else if (n_cnt < np || np == '0) state_next = S_EMIT;
        else                          state_next = S_SEQ;
      end
      S_RB_RD: state_next = S_RB_EX;
      S_RB_EX: state_next = r_end ? S_EMIT : S_RB_RD;
      S_RL_RD: state_next = S_RL_EX;
      S_RL_EX: state_next = r_end ? S_EMIT : S_RL_RD;
      S_EMIT:  if (can_emit) state_next = S_IDLE;
      S_SEQ:   if (can_emit && (e_cnt + CW'(1)) == np) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop    = 1'b0;
    max_we   = 1'b0;
    alloc_we = 1'b0;
    alloc_wd = cur.amount[UNIT_BITS-1:0];
    emit     = 1'b0;
    emit_word = '0;
    case (state)
      S_IDLE: q_pop = !q_empty;
      S_DISP: begin
        max_we   = cur.kind == K_WR_MAX && cur.p_ok && cur.r_ok;
        alloc_we = cur.kind == K_WR_ALLOC && cur.p_ok && cur.r_ok;
        alloc_wd = UNIT_BITS'(cur.amount);
      end
      S_AP_EX: begin
        alloc_we = !r_end;
        alloc_wd = alloc_rd + request_stage[ri];
      end
      S_RB_EX: begin
        alloc_we = !r_end;
        alloc_wd = alloc_rd - request_stage[ri];
      end
      S_RL_EX: begin
        alloc_we = !r_end;
        alloc_wd = '0;
      end
      S_EMIT: begin
        emit = can_emit;
        emit_word.status       = res_status;
        emit_word.is_safe      = res_safe;
        emit_word.blocked_mask = res_mask;
        emit_word.last         = 1'b1;
      end
      S_SEQ: begin
        emit = can_emit;
        emit_word.status      = STS_OK;
        emit_word.is_safe     = 1'b1;
        emit_word.seq_valid   = 1'b1;
        emit_word.seq_process = 4'(seq[e_cnt[PW-1:0]]);
        emit_word.last        = (e_cnt + CW'(1)) == np;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Matrix memories: one write and one read port each
  always_ff @(posedge clk) begin
    if (max_we)   max_mem[cfg_addr] <= UNIT_BITS'(cur.amount);
    if (alloc_we) alloc_mem[(state == S_DISP) ? cfg_addr : rd_addr] <= alloc_wd;
    max_rd   <= max_vld[rd_addr] ? max_mem[rd_addr] : '0;
    alloc_rd <= alloc_vld[rd_addr] ? alloc_mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_vld   <= '0;
      alloc_vld <= '0;
    end else begin
      if (max_we)   max_vld[cfg_addr] <= 1'b1;
      if (alloc_we) alloc_vld[(state == S_DISP) ? cfg_addr : rd_addr] <= 1'b1;
    end
  end

  // Vectors, counters and result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RESOURCES; i++) begin
        free_units[i]    <= '0;
        request_stage[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: if (!q_empty) cur <= q_head;
        S_DISP: begin
          res_status <= bad_proc ? STS_BAD_PROC : STS_OK;
          res_safe   <= 1'b0;
          res_mask   <= '0;
          r_cnt      <= '0;
          ex_any     <= 1'b0;
          na_any     <= 1'b0;
          // Writes and checks always answer ok
          if (cur.kind == K_WR_MAX || cur.kind == K_WR_ALLOC || cur.kind == K_CHECK)
            res_status <= STS_OK;
          if (cur.kind == K_WR_AVAIL) begin
            res_status <= STS_OK;
            if (cur.r_ok) free_units[RW'(cur.res_index)] <= UNIT_BITS'(cur.amount);
          end
          if ((cur.kind == K_STAGE || cur.kind == K_REQ) && cur.r_ok)
            request_stage[RW'(cur.res_index)] <= UNIT_BITS'(cur.amount);
        end
        S_EV_EX: begin
          if (!r_end) begin
            if (exceeds) ex_any <= 1'b1;
            if (request_stage[ri] > free_units[ri]) na_any <= 1'b1;
            r_cnt <= r_cnt + RCW'(1);
          end else begin
            r_cnt <= '0;
            res_status <= ex_any ? STS_EXCEEDS : STS_NOT_AVAIL;
          end
        end
        S_AP_EX: begin
          if (!r_end) begin
            free_units[ri] <= free_units[ri] - request_stage[ri];
            r_cnt <= r_cnt + RCW'(1);
          end
        end
        S_SC_INIT: begin
          for (int i = 0; i < RESOURCES; i++) work[i] <= WW'(free_units[i]);
          done     <= '0;
          n_cnt    <= '0;
          p_cnt    <= '0;
          progress <= 1'b0;
        end
        S_SC_P: begin
          if (p_end) begin
            p_cnt    <= '0;
            progress <= 1'b0;
          end else if (done[p_cnt[PW-1:0]]) begin
            p_cnt <= p_cnt + CW'(1);
          end else begin
            r_cnt <= '0;
          end
        end
        S_SC_EX: begin
          if (r_end)       r_cnt <= '0;
          else if (no_fit) p_cnt <= p_cnt + CW'(1);
          else             r_cnt <= r_cnt + RCW'(1);
        end
        S_SC_AEX: begin
          if (r_end) begin
            done[p_cnt[PW-1:0]] <= 1'b1;
            seq[n_cnt[PW-1:0]]  <= p_cnt[PW-1:0];
            n_cnt    <= n_cnt + CW'(1);
            progress <= 1'b1;
            p_cnt    <= p_cnt + CW'(1);
          end else begin
            work[ri] <= work[ri] + WW'(alloc_rd);
            r_cnt    <= r_cnt + RCW'(1);
          end
        end
        S_SC_END: begin
          r_cnt <= '0;
          e_cnt <= '0;
          if (cur.kind == K_REQ) begin
            res_status <= STS_OK;
          end else if (n_cnt < np) begin
            res_mask <= 16'(all_mask & ~done);
          end else begin
            res_safe <= 1'b1;
          end
        end
        S_RB_EX: begin
          if (!r_end) begin
            free_units[ri] <= free_units[ri] + request_stage[ri];
            r_cnt <= r_cnt + RCW'(1);
          end else begin
            res_status <= STS_UNSAFE;
          end
        end
        S_RL_EX: begin
          if (!r_end) begin
            free_units[ri] <= rel_sum[UNIT_BITS] ? '1 : rel_sum[UNIT_BITS-1:0];
            r_cnt <= r_cnt + RCW'(1);
          end
        end
        S_EMIT: begin
          if (can_emit && cur.kind == K_REQ)
            for (int i = 0; i < RESOURCES; i++) request_stage[i] <= '0;
        end
        S_SEQ: if (can_emit) e_cnt <= e_cnt + CW'(1);
        default: ;
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_word <= emit_word;
  end

endmodule

// ===== rtl/bankers_safety_allocator.sv =====
// Top level of the banker's safety allocator.
//
// Input channel in_valid/in_stall/in_word carries one command word per
// handshake: matrix and free-unit writes, request elements, release, check.
// Output channel out_valid/out_stall/out_word returns result words; a check
// of a safe state returns one word per process in use, in safe order, with
// last set on the final word. Non-final request elements return nothing.
// A front decoder feeds a two-entry command queue, so input words are still
// taken while the back end works or the receiver stalls, until the queue fills.
// A request or check is bounded by the safety scan: up to P passes over P
// processes, each process a fit test over the resources and then a pass over
// the resources to add its allocation, far less work when processes finish
// on the first pass.
// The matrices are read through one registered memory port each.
// Synchronous reset rst clears the sequencer, the matrix valid bits, the
// free and staged unit vectors, the counts and the queue.
// When out_stall is high the result word holds and the back end waits.
// Configuration writes (cfg_we, cfg_index, cfg_data) must be issued only
// while the block is idle.
module bankers_safety_allocator import bsa_pkg::*; #(
  parameter int PROCS     = 16,
  parameter int RESOURCES = 8,
  parameter int UNIT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_word,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);

  logic [4:0] process_count;
  logic [3:0] resource_count;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  cmd_t       q_cmd;
  cmd_t       q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= '0;
      resource_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROCESS_COUNT:  process_count  <= cfg_data;
        CFG_RESOURCE_COUNT: resource_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  bsa_front #(.PROCS(PROCS), .RESOURCES(RESOURCES)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  bsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  bsa_back #(.PROCS(PROCS), .RESOURCES(RESOURCES), .UNIT_BITS(UNIT_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .process_count  (process_count),
    .resource_count (resource_count),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word)
  );

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_no_overflow, !(q_push && q_full))
  `ASSERT_ALWAYS(a_no_underflow, !(q_pop && q_empty))
  `ASSERT_NEXT(a_push_seen, q_push && !q_pop, !q_empty)
  `ASSERT_ALWAYS(a_seq_safe, !out_valid || !out_word.seq_valid || out_word.is_safe)

endmodule

// ===== verif/bsa_checker.sv =====
// Checker for the banker's safety allocator: predicts result words and compares them.
module bsa_checker import bsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_t        in_word,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_t       out_word,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPROC = 16;
  localparam int NRES  = 8;
  localparam logic [15:0] UNIT_MAX = 16'hFFFF;

  // Shadow copy of the allocator state
  logic [15:0] claim_tab [NPROC][NRES];
  logic [15:0] held_tab  [NPROC][NRES];
  logic [15:0] free_tab  [NRES];
  logic [15:0] stage_tab [NRES];
  int unsigned proc_cfg, res_cfg;
  out_t expected_q [$];

  function automatic int procs_in_use();
    return (proc_cfg > NPROC) ? NPROC : proc_cfg;
  endfunction

  function automatic int res_in_use();
    return (res_cfg > NRES) ? NRES : res_cfg;
  endfunction

  function automatic longint need_of(int p, int r);
    return longint'(claim_tab[p][r]) - longint'(held_tab[p][r]);
  endfunction

  function automatic void expect_word(status_t st, logic safe, logic sv, logic [3:0] sp,
                                      logic [15:0] mask, logic fin);
    out_t w;
    w.status = st;
    w.is_safe = safe;
    w.seq_valid = sv;
    w.seq_process = sp;
    w.blocked_mask = mask;
    w.last = fin;
    expected_q.push_back(w);
  endfunction

  // Safety scan: repeated passes in process order until a pass finishes nobody or all are finished
  function automatic void safe_order(output int order [NPROC], output int count,
                                     output logic [15:0] finished);
    longint work [NRES];
    int np, nr;
    bit progress, fits;
    np = procs_in_use();
    nr = res_in_use();
    count = 0;
    finished = '0;
    foreach (order[i]) order[i] = 0;
    for (int r = 0; r < nr; r++) work[r] = free_tab[r];
    progress = 1;
    while (progress && count < np) begin
      progress = 0;
      for (int p = 0; p < np; p++) begin
        if (finished[p]) continue;
        fits = 1;
        for (int r = 0; r < nr; r++)
          if (need_of(p, r) > work[r]) fits = 0;
        if (fits) begin
          for (int r = 0; r < nr; r++) work[r] += held_tab[p][r];
          finished[p] = 1;
          order[count] = p;
          count++;
          progress = 1;
        end
      end
    end
  endfunction

  // Final request element: limits, tentative grant, safety, rollback
  function automatic status_t grant_request(int p);
    int nr, order [NPROC], count;
    logic [15:0] finished;
    nr = res_in_use();
    if (p >= procs_in_use()) return STS_BAD_PROC;
    for (int r = 0; r < nr; r++)
      if (longint'(stage_tab[r]) > need_of(p, r)) return STS_EXCEEDS;
    for (int r = 0; r < nr; r++)
      if (stage_tab[r] > free_tab[r]) return STS_NOT_AVAIL;
    for (int r = 0; r < nr; r++) begin
      free_tab[r] -= stage_tab[r];
      held_tab[p][r] += stage_tab[r];
    end
    safe_order(order, count, finished);
    if (count == procs_in_use()) return STS_OK;
    for (int r = 0; r < nr; r++) begin
      free_tab[r] += stage_tab[r];
      held_tab[p][r] -= stage_tab[r];
    end
    return STS_UNSAFE;
  endfunction

  function automatic void predict(in_t w);
    int p, r, np, count, order [NPROC];
    logic [15:0] finished, all_mask;
    logic [16:0] sum;
    p = w.proc_index;
    r = w.res_index;
    np = procs_in_use();
    case (w.opcode)
      OP_WR_MAX: begin
        claim_tab[p][r] = w.amount;
        expect_word(STS_OK, 0, 0, 0, 0, 1);
      end
      OP_WR_ALLOC: begin
        held_tab[p][r] = w.amount;
        expect_word(STS_OK, 0, 0, 0, 0, 1);
      end
      OP_WR_AVAIL: begin
        free_tab[r] = w.amount;
        expect_word(STS_OK, 0, 0, 0, 0, 1);
      end
      OP_REQUEST: begin
        stage_tab[r] = w.amount;
        if (w.final_element) begin
          expect_word(grant_request(p), 0, 0, 0, 0, 1);
          foreach (stage_tab[i]) stage_tab[i] = '0;
        end
      end
      OP_RELEASE: begin
        if (p >= np) begin
          expect_word(STS_BAD_PROC, 0, 0, 0, 0, 1);
        end else begin
          for (int i = 0; i < res_in_use(); i++) begin
            sum = free_tab[i] + held_tab[p][i];
            free_tab[i] = sum[16] ? UNIT_MAX : sum[15:0];
            held_tab[p][i] = '0;
          end
          expect_word(STS_OK, 0, 0, 0, 0, 1);
        end
      end
      OP_CHECK: begin
        safe_order(order, count, finished);
        all_mask = (np >= NPROC) ? '1 : 16'((1 << np) - 1);
        if (count < np)
          expect_word(STS_OK, 0, 0, 0, all_mask & ~finished, 1);
        else if (np == 0)
          expect_word(STS_OK, 1, 0, 0, 0, 1);
        else
          for (int i = 0; i < np; i++)
            expect_word(STS_OK, 1, 1, 4'(order[i]), 0, i + 1 == np);
      end
      default: ;  // spare opcodes are dropped
    endcase
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (claim_tab[i, j]) begin
        claim_tab[i][j] = '0;
        held_tab[i][j] = '0;
      end
      foreach (free_tab[i]) begin
        free_tab[i] = '0;
        stage_tab[i] = '0;
      end
      proc_cfg = 0;
      res_cfg = 0;
      expected_q.delete();
      fail_count = 0;
      words_checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PROCESS_COUNT) proc_cfg = cfg_data;
        else res_cfg = cfg_data[3:0];
      end
      if (in_valid && !in_stall) predict(in_word);
      // Result word against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected word", out_word, 0);
        end else begin
          out_t want;
          want = expected_q.pop_front();
          words_checked++;
          if (out_word.status !== want.status) report("status", out_word.status, want.status);
          if (out_word.is_safe !== want.is_safe) report("is_safe", out_word.is_safe, want.is_safe);
          if (out_word.seq_valid !== want.seq_valid)
            report("seq_valid", out_word.seq_valid, want.seq_valid);
          if (out_word.seq_process !== want.seq_process)
            report("seq_process", out_word.seq_process, want.seq_process);
          if (out_word.blocked_mask !== want.blocked_mask)
            report("blocked_mask", out_word.blocked_mask, want.blocked_mask);
          if (out_word.last !== want.last) report("last", out_word.last, want.last);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// ===== verif/bankers_safety_allocator_test.sv =====
// Testbench top for the banker's safety allocator: stimulus, stalls and verdict.
module bankers_safety_allocator_test import bsa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 200;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t  in_word;
  out_t out_word;
  logic cfg_we, cfg_index;
  logic [4:0] cfg_data;
  int fail_count, pending, words_checked;
  int gap_pct, stall_pct, words_sent, quiet_cycles, cur_procs;

  bankers_safety_allocator dut (.*);

  bsa_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_t make_word(logic [2:0] op, int p, int r, int amt, bit fin);
    in_t w;
    w.opcode = op;
    w.proc_index = 4'(p);
    w.res_index = 3'(r);
    w.amount = 16'(amt);
    w.final_element = fin;
    return w;
  endfunction

  task automatic send_word(in_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Hold off until every expected word is back, then let the back end settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(int procs, int res);
    cfg_we <= 1;
    cfg_index <= CFG_PROCESS_COUNT;
    cfg_data <= 5'(procs);
    @(posedge clk);
    cfg_index <= CFG_RESOURCE_COUNT;
    cfg_data <= 5'(res);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    cur_procs = procs > 16 ? 16 : procs;
  endtask

  function automatic int pick_amount(int hi);
    return ($urandom_range(99) < 8) ? $urandom_range(16'hFFFF) : $urandom_range(hi);
  endfunction

  function automatic int pick_proc();
    if (cur_procs > 0 && $urandom_range(99) < 85) return $urandom_range(cur_procs - 1);
    return $urandom_range(15);
  endfunction

  // Plausible tables: free units, claims and holdings for all processes
  task automatic load_tables();
    for (int r = 0; r < 8; r++) send_word(make_word(OP_WR_AVAIL, 0, r, pick_amount(30), 0));
    for (int p = 0; p < cur_procs; p++) begin
      for (int r = $urandom_range(3); r < 8; r += 4 + $urandom_range(3)) begin
        send_word(make_word(OP_WR_MAX, p, r, $urandom_range(12), $urandom_range(1)));
        send_word(make_word(OP_WR_ALLOC, p, r, $urandom_range(4), $urandom_range(1)));
      end
    end
  endtask

  task automatic random_ops(int count);
    int kind, elems, p, start;
    start = words_sent;
    while (words_sent - start < count) begin
      kind = $urandom_range(99);
      p = pick_proc();
      if (kind < 40) begin
        elems = $urandom_range(1, 8);
        for (int e = 0; e < elems; e++)
          send_word(make_word(OP_REQUEST, p, $urandom_range(7), pick_amount(5), e == elems - 1));
      end else if (kind < 52) send_word(make_word(OP_WR_MAX, p, $urandom_range(7),
                                                  pick_amount(15), $urandom_range(1)));
      else if (kind < 60) send_word(make_word(OP_WR_ALLOC, p, $urandom_range(7),
                                              pick_amount(5), $urandom_range(1)));
      else if (kind < 68) send_word(make_word(OP_WR_AVAIL, p, $urandom_range(7),
                                              pick_amount(30), $urandom_range(1)));
      else if (kind < 78) send_word(make_word(OP_RELEASE, p, $urandom_range(7),
                                              $urandom_range(16'hFFFF), $urandom_range(1)));
      else if (kind < 94) send_word(make_word(OP_CHECK, p, $urandom_range(7),
                                              $urandom_range(16'hFFFF), $urandom_range(1)));
      else begin
        // spare opcodes do not count toward the total
        send_word(make_word($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B, p,
                            $urandom_range(7), $urandom_range(16'hFFFF), $urandom_range(1)));
        words_sent--;
      end
    end
  endtask

  initial begin
    int settings [6][2];
    settings = '{'{16, 8}, '{31, 15}, '{1, 1}, '{0, 0}, '{5, 4}, '{16, 3}};
    rst = 1;
    in_valid = 0;
    in_word = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = CFG_PROCESS_COUNT;
    cfg_data = '0;
    gap_pct = 0;
    stall_pct = 0;
    words_sent = 0;
    cur_procs = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: limits, saturation, bad process, spare opcodes
    write_cfg(4, 3);
    send_word(make_word(OP_CHECK, 0, 0, 0, 0));
    send_word(make_word(OP_WR_AVAIL, 0, 0, 16'hFFFF, 0));
    send_word(make_word(OP_WR_AVAIL, 0, 1, 10, 1));
    send_word(make_word(OP_WR_AVAIL, 0, 2, 2, 0));
    send_word(make_word(OP_WR_MAX, 0, 0, 3, 0));
    send_word(make_word(OP_WR_ALLOC, 0, 0, 1, 0));
    send_word(make_word(OP_REQUEST, 0, 0, 5, 1));
    send_word(make_word(OP_WR_MAX, 1, 1, 16'hFFFF, 0));
    send_word(make_word(OP_REQUEST, 1, 1, 15, 1));
    send_word(make_word(OP_WR_MAX, 2, 2, 9, 0));
    send_word(make_word(OP_WR_MAX, 3, 2, 9, 0));
    send_word(make_word(OP_REQUEST, 2, 7, 16'hFFFF, 0));
    send_word(make_word(OP_REQUEST, 2, 2, 2, 1));
    send_word(make_word(OP_REQUEST, 1, 1, 3, 1));
    send_word(make_word(OP_CHECK, 15, 7, 16'hFFFF, 1));
    send_word(make_word(OP_RELEASE, 0, 0, 0, 0));
    send_word(make_word(OP_RELEASE, 9, 0, 0, 0));
    send_word(make_word(OP_REQUEST, 15, 0, 0, 1));
    send_word(make_word(OP_SPARE_A, 0, 0, 0, 0));
    send_word(make_word(OP_SPARE_B, 15, 7, 16'hFFFF, 1));
    send_word(make_word(OP_CHECK, 0, 0, 0, 0));
    drain();

    // Random phases over register settings and idling patterns
    foreach (settings[i]) begin
      write_cfg(settings[i][0], settings[i][1]);
      case (i % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 65; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 65; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      load_tables();
      random_ops(18);
      drain();
    end

    $display("sent %0d command words over %0d settings, checked %0d result words",
             words_sent, $size(settings) + 1, words_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d words never arrived", fail_count, pending);
      $display("status: fail");
    end
    $finish;
  end
endmodule
